FILE: design/segrect_pkg.sv
// ----------------------------------------------------------------------------
// segrect_pkg
// Shared widths, types and helper functions for the segment/rectangle
// edge intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package segrect_pkg;

	// coordinate width; every other width follows from it
	localparam int COORD_BITS = 16;
	// offsets such as (x - left - width) need two extra bits
	localparam int DIFF_BITS  = COORD_BITS + 2;
	// products and differences of products
	localparam int PROD_BITS  = 2 * DIFF_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-2:0] dim_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic        [PROD_BITS-1:0]  mag_t;

	// sign/magnitude form of a product term
	typedef struct packed {
		logic nz;
		logic neg;
		mag_t mag;
	} sm_t;

	// split a two's complement value into nonzero flag, sign and magnitude
	function automatic sm_t to_sm(prod_t q);
		sm_t r;
		r.nz  = (q != '0);
		r.neg = q[PROD_BITS-1];
		r.mag = r.neg ? mag_t'(-q) : mag_t'(q);
		return r;
	endfunction

	// negate a sign/magnitude value (only the sign of a nonzero value matters)
	function automatic sm_t neg_sm(sm_t a);
		sm_t r;
		r     = a;
		r.neg = ~a.neg;
		return r;
	endfunction

	// num/den lies in [0,1], den known nonzero
	function automatic logic unit_ok(sm_t n, sm_t d);
		return !n.nz || ((n.neg == d.neg) && (n.mag <= d.mag));
	endfunction

	// both segment parameters in range on a non-parallel edge
	function automatic logic edge_ok(sm_t na, sm_t nb, sm_t d);
		return d.nz && unit_ok(na, d) && unit_ok(nb, d);
	endfunction

endpackage

`default_nettype wire

FILE: design/segment_rectangle_intersect_unit.sv
// Throughput: one query per cycle; a new query is taken every cycle the
// output is taken or some pipeline stage is empty.
// The depth is set by the offset, multiply, subtract, sign/magnitude and
// compare stages. Reset clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_unit
// Five-stage pipeline that reports whether a segment touches or crosses any
// edge of an axis-aligned rectangle, using exact integer cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_rectangle_intersect_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire segrect_pkg::coord_t start_x,
	input  wire segrect_pkg::coord_t start_y,
	input  wire segrect_pkg::coord_t end_x,
	input  wire segrect_pkg::coord_t end_y,
	input  wire segrect_pkg::coord_t box_left,
	input  wire segrect_pkg::coord_t box_top,
	input  wire segrect_pkg::dim_t   box_width,
	input  wire segrect_pkg::dim_t   box_height,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit
);

	import segrect_pkg::*;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// stage 1 combinational offsets
	diff_t ox_c, oy_c, ox2_c, oy2_c;
	diff_t qx_c, qy_c, qx2_c, qy2_c;
	diff_t sx_c, sy_c;
	logic  shared_c;

	// stage 1 registers
	logic  shared_s1;
	diff_t sx_s1, sy_s1, ox_s1, oy_s1, ox2_s1, oy2_s1, w_s1, h_s1;

	// stage 2 registers: products
	logic  shared_s2;
	prod_t p_hsx_s2, p_wsy_s2, p_hox_s2, p_woy_s2, p_woy2_s2, p_hox2_s2;
	prod_t p_sxoy_s2, p_syox_s2, p_sxoy2_s2, p_syox2_s2;

	// stage 3 registers: numerators and denominators
	logic  shared_s3;
	prod_t a_s3, b_s3, c_s3, d_s3, nb1_s3, nb3_s3, den_p_s3, den_q_s3;

	// stage 4 registers: sign/magnitude form
	logic  shared_s4;
	sm_t   sa_s4, sb_s4, sc_s4, sd_s4, sn1_s4, sn3_s4, sp_s4, sq_s4;

	// stage 5 register: result
	logic  hit_s5;

	// a stage loads when empty or when the next one moves on
	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign out_valid = v_s5;
	assign hit       = hit_s5;

	// offsets of both endpoints from the near and far rectangle corners
	assign ox_c  = diff_t'(start_x) - diff_t'(box_left);
	assign oy_c  = diff_t'(start_y) - diff_t'(box_top);
	assign ox2_c = ox_c - diff_t'(box_width);
	assign oy2_c = oy_c - diff_t'(box_height);
	assign qx_c  = diff_t'(end_x) - diff_t'(box_left);
	assign qy_c  = diff_t'(end_y) - diff_t'(box_top);
	assign qx2_c = qx_c - diff_t'(box_width);
	assign qy2_c = qy_c - diff_t'(box_height);
	assign sx_c  = diff_t'(end_x) - diff_t'(start_x);
	assign sy_c  = diff_t'(end_y) - diff_t'(start_y);

	// an endpoint sitting on any rectangle corner counts as a hit
	assign shared_c = ((ox_c == '0 || ox2_c == '0) && (oy_c == '0 || oy2_c == '0)) ||
	                  ((qx_c == '0 || qx2_c == '0) && (qy_c == '0 || qy2_c == '0));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: offsets and corner match
	always_ff @(posedge clk) begin
		if (en1) begin
			shared_s1 <= shared_c;
			sx_s1     <= sx_c;
			sy_s1     <= sy_c;
			ox_s1     <= ox_c;
			oy_s1     <= oy_c;
			ox2_s1    <= ox2_c;
			oy2_s1    <= oy2_c;
			w_s1      <= diff_t'(box_width);
			h_s1      <= diff_t'(box_height);
		end
	end

	// stage 2: cross product terms, axis-aligned edges drop half of them
	always_ff @(posedge clk) begin
		if (en2) begin
			shared_s2  <= shared_s1;
			p_hsx_s2   <= prod_t'(h_s1) * prod_t'(sx_s1);
			p_wsy_s2   <= prod_t'(w_s1) * prod_t'(sy_s1);
			p_hox_s2   <= prod_t'(h_s1) * prod_t'(ox_s1);
			p_woy_s2   <= prod_t'(w_s1) * prod_t'(oy_s1);
			p_woy2_s2  <= prod_t'(w_s1) * prod_t'(oy2_s1);
			p_hox2_s2  <= prod_t'(h_s1) * prod_t'(ox2_s1);
			p_sxoy_s2  <= prod_t'(sx_s1) * prod_t'(oy_s1);
			p_syox_s2  <= prod_t'(sy_s1) * prod_t'(ox_s1);
			p_sxoy2_s2 <= prod_t'(sx_s1) * prod_t'(oy2_s1);
			p_syox2_s2 <= prod_t'(sy_s1) * prod_t'(ox2_s1);
		end
	end

	// stage 3: segment numerators for the near and far corner
	always_ff @(posedge clk) begin
		if (en3) begin
			shared_s3 <= shared_s2;
			a_s3      <= p_hox_s2;
			b_s3      <= p_woy_s2;
			c_s3      <= p_woy2_s2;
			d_s3      <= p_hox2_s2;
			nb1_s3    <= p_sxoy_s2 - p_syox_s2;
			nb3_s3    <= p_sxoy2_s2 - p_syox2_s2;
			den_p_s3  <= p_hsx_s2;
			den_q_s3  <= p_wsy_s2;
		end
	end

	// stage 4: sign and magnitude of every term
	always_ff @(posedge clk) begin
		if (en4) begin
			shared_s4 <= shared_s3;
			sa_s4     <= to_sm(a_s3);
			sb_s4     <= to_sm(b_s3);
			sc_s4     <= to_sm(c_s3);
			sd_s4     <= to_sm(d_s3);
			sn1_s4    <= to_sm(nb1_s3);
			sn3_s4    <= to_sm(nb3_s3);
			sp_s4     <= to_sm(den_p_s3);
			sq_s4     <= to_sm(den_q_s3);
		end
	end

	// stage 5: range checks per edge (left, top, bottom, right)
	always_ff @(posedge clk) begin
		if (en5) begin
			hit_s5 <= shared_s4 ||
			          edge_ok(neg_sm(sa_s4), sn1_s4, sp_s4) ||
			          edge_ok(sb_s4, sn1_s4, neg_sm(sq_s4)) ||
			          edge_ok(neg_sm(sc_s4), sn3_s4, sq_s4) ||
			          edge_ok(sd_s4, sn3_s4, neg_sm(sp_s4));
		end
	end

endmodule

`default_nettype wire

FILE: design/segrect_checker.sv
// ----------------------------------------------------------------------------
// segrect_checker
// Port-level checks of the intersection pipeline: stall behavior, flow
// through when the output is taken, and fixed latency.
// ----------------------------------------------------------------------------
`default_nettype none

module segrect_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic hit
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit))
		else $error("result changed while stalled");

	// taking the output frees room for a new transfer
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output is taken");

	// input only blocks when a finished result is waiting
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked with output free");

	// a transfer with the output kept open shows up as a valid result at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
		##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind segment_rectangle_intersect_unit segrect_checker u_segrect_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams segment/rectangle queries through segment_rectangle_intersect_unit.
// It predicts each hit flag with exact 64-bit cross products and checks the
// returned flags in order, with random idle bursts on both channels, one long
// output hold-off and one input pause that drains the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
	import segrect_pkg::*;

	localparam int     RESET_CYCLES   = 7;
	localparam int     RANDOM_ITEMS   = 1400;
	localparam int     TAIL_ITEMS     = 150;
	localparam int     HOLD_AT        = 300;
	localparam int     HOLD_CYCLES    = 90;
	localparam int     PAUSE_AT       = 700;
	localparam int     DRAIN_CYCLES   = 12;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     REPORT_LIMIT   = 10;
	localparam longint COORD_MIN      = -(longint'(1) <<< (COORD_BITS - 1));
	localparam longint COORD_MAX      = (longint'(1) <<< (COORD_BITS - 1)) - 1;
	localparam longint DIM_MAX        = (longint'(1) <<< (COORD_BITS - 1)) - 1;

	typedef struct {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		coord_t box_left;
		coord_t box_top;
		dim_t   box_width;
		dim_t   box_height;
	} segment_query_t;

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   in_valid   = 1'b0;
	logic   in_ready;
	coord_t start_x    = '0;
	coord_t start_y    = '0;
	coord_t end_x      = '0;
	coord_t end_y      = '0;
	coord_t box_left   = '0;
	coord_t box_top    = '0;
	dim_t   box_width  = '0;
	dim_t   box_height = '0;
	logic   out_valid;
	logic   out_ready  = 1'b0;
	logic   hit;

	segment_query_t pending_q[$];
	logic           hit_expect_q[$];
	segment_query_t cur_query;
	logic           tail_phase     = 1'b0;
	int             gap_left       = 0;
	int             stall_left     = 0;
	int             hold_left      = 0;
	logic           hold_done      = 1'b0;
	logic           pause_done     = 1'b0;
	logic           offer;
	logic           take;
	logic           want_hit;
	int             accepted_count = 0;
	int             results_seen   = 0;
	int             mismatch_count = 0;
	int             quiet_cycles   = 0;

	segment_rectangle_intersect_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit)
	);

	// num/den lies in [0,1]; den is nonzero
	function automatic bit param_in_unit(longint num, longint den);
		if (num == 0)
			return 1'b1;
		if ((num < 0) != (den < 0))
			return 1'b0;
		return ((num < 0) ? -num : num) <= ((den < 0) ? -den : den);
	endfunction

	// segment a-b against edge c-d
	function automatic bit edge_touched(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		longint ex, ey, sx, sy, ox, oy, num_a, num_b, den;
		if ((ax == cx && ay == cy) || (ax == dx && ay == dy) ||
				(bx == cx && by == cy) || (bx == dx && by == dy))
			return 1'b1;
		ex    = dx - cx;
		ey    = dy - cy;
		sx    = bx - ax;
		sy    = by - ay;
		ox    = ax - cx;
		oy    = ay - cy;
		num_a = ex * oy - ey * ox;
		num_b = sx * oy - sy * ox;
		den   = ey * sx - ex * sy;
		// parallel or collinear edge, or a point
		if (den == 0)
			return 1'b0;
		return param_in_unit(num_a, den) && param_in_unit(num_b, den);
	endfunction

	// hit flag for one query: left, top, bottom and right edges
	function automatic logic predict_hit(segment_query_t q);
		longint ax, ay, bx, by, l, t, r, b;
		ax = longint'(q.start_x);
		ay = longint'(q.start_y);
		bx = longint'(q.end_x);
		by = longint'(q.end_y);
		l  = longint'(q.box_left);
		t  = longint'(q.box_top);
		r  = l + longint'(q.box_width);
		b  = t + longint'(q.box_height);
		return edge_touched(ax, ay, bx, by, l, t, l, b) ||
			edge_touched(ax, ay, bx, by, l, t, r, t) ||
			edge_touched(ax, ay, bx, by, r, b, l, b) ||
			edge_touched(ax, ay, bx, by, r, b, r, t);
	endfunction

	// uniform coordinate in [lo, hi], clipped to the field range
	function automatic coord_t pick_coord(longint lo, longint hi);
		longint v;
		if (lo < COORD_MIN)
			lo = COORD_MIN;
		if (hi > COORD_MAX)
			hi = COORD_MAX;
		if (hi < lo)
			hi = lo;
		v = lo + longint'($urandom_range(0, int'(hi - lo)));
		return coord_t'(v);
	endfunction

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 4))
			0: return coord_t'(COORD_MIN);
			1: return coord_t'(COORD_MAX);
			2: return coord_t'(0);
			3: return coord_t'(-1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic dim_t extreme_dim();
		case ($urandom_range(0, 2))
			0: return dim_t'(0);
			1: return dim_t'(DIM_MAX);
			default: return dim_t'($urandom);
		endcase
	endfunction

	// one random query; most are local to the box so that edges get touched
	function automatic segment_query_t make_query();
		segment_query_t q;
		longint l, t, r, b;
		coord_t px, py;
		q.box_left   = pick_coord(-30000, 28000);
		q.box_top    = pick_coord(-30000, 28000);
		q.box_width  = dim_t'($urandom_range(0, 2500));
		q.box_height = dim_t'($urandom_range(0, 2500));
		l            = longint'(q.box_left);
		t            = longint'(q.box_top);
		r            = l + longint'(q.box_width);
		b            = t + longint'(q.box_height);
		q.start_x    = pick_coord(l - 400, r + 400);
		q.start_y    = pick_coord(t - 400, b + 400);
		q.end_x      = pick_coord(l - 400, r + 400);
		q.end_y      = pick_coord(t - 400, b + 400);
		case ($urandom_range(0, 9))
			// anything at all
			0, 1: begin
				q.start_x    = coord_t'($urandom);
				q.start_y    = coord_t'($urandom);
				q.end_x      = coord_t'($urandom);
				q.end_y      = coord_t'($urandom);
				q.box_left   = coord_t'($urandom);
				q.box_top    = coord_t'($urandom);
				q.box_width  = dim_t'($urandom);
				q.box_height = dim_t'($urandom);
			end
			// start point lies on an edge
			5: begin
				case ($urandom_range(0, 3))
					0: begin q.start_x = coord_t'(l); q.start_y = pick_coord(t, b); end
					1: begin q.start_x = pick_coord(l, r); q.start_y = coord_t'(t); end
					2: begin q.start_x = coord_t'(r); q.start_y = pick_coord(t, b); end
					default: begin q.start_x = pick_coord(l, r); q.start_y = coord_t'(b); end
				endcase
			end
			// segment runs along the line of an edge
			6: begin
				if ($urandom_range(0, 1) == 0) begin
					py        = coord_t'(($urandom_range(0, 1) == 0) ? t : b);
					q.start_y = py;
					q.end_y   = py;
				end else begin
					px        = coord_t'(($urandom_range(0, 1) == 0) ? l : r);
					q.start_x = px;
					q.end_x   = px;
				end
			end
			// single point segment, often on a corner
			7: begin
				if ($urandom_range(0, 1) == 0) begin
					q.start_x = coord_t'(($urandom_range(0, 1) == 0) ? l : r);
					q.start_y = coord_t'(($urandom_range(0, 1) == 0) ? t : b);
				end
				q.end_x = q.start_x;
				q.end_y = q.start_y;
			end
			// flat or point box
			8: begin
				case ($urandom_range(0, 2))
					0: q.box_width = '0;
					1: q.box_height = '0;
					default: begin q.box_width = '0; q.box_height = '0; end
				endcase
			end
			// corners of the value range
			9: begin
				q.start_x    = extreme_coord();
				q.start_y    = extreme_coord();
				q.end_x      = extreme_coord();
				q.end_y      = extreme_coord();
				q.box_left   = extreme_coord();
				q.box_top    = extreme_coord();
				q.box_width  = extreme_dim();
				q.box_height = extreme_dim();
			end
			default: ;
		endcase
		return q;
	endfunction

	task automatic queue_query(int sx, int sy, int ex, int ey, int l, int t, int w, int h);
		segment_query_t q;
		q.start_x    = coord_t'(sx);
		q.start_y    = coord_t'(sy);
		q.end_x      = coord_t'(ex);
		q.end_y      = coord_t'(ey);
		q.box_left   = coord_t'(l);
		q.box_top    = coord_t'(t);
		q.box_width  = dim_t'(w);
		q.box_height = dim_t'(h);
		pending_q.push_back(q);
	endtask

	task automatic note_mismatch(string what, logic want, logic got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s: expected hit %b, got %b", $time, what, want, got);
	endtask

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// input driver: one query per transfer, random idle bursts between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				hit_expect_q.push_back(predict_hit(cur_query));
				accepted_count++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (accepted_count == PAUSE_AT && !pause_done) begin
					// let the pipeline run dry once
					if (hit_expect_q.size() == 0)
						pause_done = 1'b1;
				end else if (pending_q.size() != 0) begin
					cur_query = pending_q.pop_front();
					start_x    <= cur_query.start_x;
					start_y    <= cur_query.start_y;
					end_x      <= cur_query.end_x;
					end_y      <= cur_query.end_y;
					box_left   <= cur_query.box_left;
					box_top    <= cur_query.box_top;
					box_width  <= cur_query.box_width;
					box_height <= cur_query.box_height;
					offer = 1'b1;
					if (!tail_phase && $urandom_range(0, 9) == 0)
						gap_left = $urandom_range(1, 18);
				end
			end
			in_valid   <= offer;
			tail_phase <= (pending_q.size() < TAIL_ITEMS);
		end
	end

	// output monitor and ready control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (hit_expect_q.size() == 0) begin
					note_mismatch("result with nothing pending", 1'bx, hit);
				end else begin
					want_hit = hit_expect_q.pop_front();
					if (hit !== want_hit)
						note_mismatch("hit flag", want_hit, hit);
				end
			end
			take = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				// long hold-off so the pipeline fills and backs up the input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				take      = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 17);
				take       = 1'b0;
			end
			out_ready <= take;
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin
		int i;
		// crossing, inside, outside
		queue_query(-50, 50, 150, 50, 0, 0, 100, 100);
		queue_query(10, 10, 90, 90, 0, 0, 100, 100);
		queue_query(200, 200, 300, 250, 0, 0, 100, 100);
		// endpoint shared with a corner, endpoint on an edge, one stopping just short of it
		queue_query(0, 0, -50, -70, 0, 0, 100, 100);
		queue_query(50, 0, 50, -40, 0, 0, 100, 100);
		queue_query(50, -40, 50, -1, 0, 0, 100, 100);
		// collinear with an edge: inside it, meeting a corner, through corners; parallel outside
		queue_query(10, 0, 90, 0, 0, 0, 100, 100);
		queue_query(100, 0, 150, 0, 0, 0, 100, 100);
		queue_query(-10, 0, 200, 0, 0, 0, 100, 100);
		queue_query(-10, -10, -10, 200, 0, 0, 100, 100);
		// point segments: on a corner, on an edge, inside
		queue_query(100, 100, 100, 100, 0, 0, 100, 100);
		queue_query(50, 0, 50, 0, 0, 0, 100, 100);
		queue_query(40, 60, 40, 60, 0, 0, 100, 100);
		// flat and point boxes
		queue_query(-10, 50, 10, 50, 0, 0, 0, 100);
		queue_query(0, 0, 10, 10, 5, 5, 0, 0);
		queue_query(5, 5, 20, 3, 5, 5, 0, 0);
		// extremes of every field
		queue_query(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
		queue_query(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767);
		queue_query(-32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767);
		queue_query(-1, -1, -1, -1, -1, -1, 32767, 0);
		queue_query(-32768, 0, 32767, 0, -32768, -32768, 32767, 32767);
		for (i = 0; i < RANDOM_ITEMS; i++)
			pending_q.push_back(make_query());

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || in_valid)
			@(posedge clk);
		while (hit_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: filelist.f
design/segrect_pkg.sv
design/segment_rectangle_intersect_unit.sv
design/segrect_checker.sv
test/tb_top.sv
